// ===== hw/rtl/pli_pkg.sv =====
// Package for the piecewise linear interpolator.
// Field widths, stream packing, mode codes and the controller state type.
// No dependencies.
package pli_pkg;

	localparam int DATA_W  = 16;
	localparam int IDX_W   = 4;
	localparam int CNT_W   = 5;
	localparam int PROD_W  = 2 * DATA_W;
	localparam int ENTRY_W = 2 * DATA_W;

	localparam int S_TDATA_W = 56;
	localparam int S_IDX_LO  = 0;
	localparam int S_X_LO    = S_IDX_LO + IDX_W;
	localparam int S_Y_LO    = S_X_LO + DATA_W;
	localparam int S_SMP_LO  = S_Y_LO + DATA_W;

	localparam logic [CNT_W-1:0] POINT_COUNT_RESET = 5'd9;

	localparam logic MODE_LOAD   = 1'b0;
	localparam logic MODE_LOOKUP = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHK0,
		ST_CHKL,
		ST_SCAN,
		ST_MUL,
		ST_DIV_START,
		ST_DIV,
		ST_FIN
	} pli_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

endpackage

// ===== hw/rtl/piecewise_linear_interpolator.sv =====
// Piecewise linear interpolator: maps a sample through a table of up to
// MAX_POINTS breakpoint pairs. A load beat is written as it is accepted. A
// lookup first checks the sample against the first and the last point and
// clamps there; one that interpolates reads the table memory one
// breakpoint per cycle and takes its quotient from a bit-serial divider,
// one bit per cycle over the 32-bit product. One item is in work at a
// time; a finished result sits in an output register while the next beat
// is taken. Table entries read before they are written return undefined
// data.
// Top level: APB register, output register, pli_ctrl, pli_table, pli_divider.
module piecewise_linear_interpolator #(
	parameter int MAX_POINTS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// point_index[3:0], point_x[19:4], point_y[35:20], sample[51:36], zero pad
	input  logic [pli_pkg::S_TDATA_W-1:0] s_tdata,
	// mode[0]
	input  logic                          s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// mapped_value[15:0]
	output logic [pli_pkg::DATA_W-1:0]    m_tdata,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [2:0]                    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	import pli_pkg::*;

	localparam int AW = $clog2(MAX_POINTS);

	logic [CNT_W-1:0]   count_q;
	logic               m_valid_q;
	logic [DATA_W-1:0]  m_data_q;
	logic               out_free;
	logic               res_valid;
	logic [DATA_W-1:0]  res_value;

	logic               tbl_we;
	logic [AW-1:0]      tbl_waddr, tbl_raddr;
	logic [ENTRY_W-1:0] tbl_wdata, tbl_rdata;

	logic               div_start;
	logic [PROD_W-1:0]  div_dividend, div_quotient;
	logic [DATA_W-1:0]  div_divisor;
	div_status_t        div_status;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? {{(32-CNT_W){1'b0}}, count_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= POINT_COUNT_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
			count_q <= pwdata[CNT_W-1:0];
		end
	end

	assign out_free = !m_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_free) begin
			m_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && res_valid) begin
			m_data_q <= res_value;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	pli_ctrl #(
		.MAX_POINTS(MAX_POINTS),
		.AW        (AW)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.point_count (count_q),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.in_mode     (s_tuser),
		.in_index    (s_tdata[S_IDX_LO +: IDX_W]),
		.in_x        (s_tdata[S_X_LO +: DATA_W]),
		.in_y        (s_tdata[S_Y_LO +: DATA_W]),
		.in_sample   (s_tdata[S_SMP_LO +: DATA_W]),
		.tbl_we      (tbl_we),
		.tbl_waddr   (tbl_waddr),
		.tbl_wdata   (tbl_wdata),
		.tbl_raddr   (tbl_raddr),
		.tbl_rdata   (tbl_rdata),
		.div_start   (div_start),
		.div_dividend(div_dividend),
		.div_divisor (div_divisor),
		.div_quotient(div_quotient),
		.div_status  (div_status),
		.out_free    (out_free),
		.res_valid   (res_valid),
		.res_value   (res_value)
	);

	pli_table #(
		.DEPTH(MAX_POINTS),
		.AW   (AW)
	) u_table (
		.clk  (clk),
		.we   (tbl_we),
		.waddr(tbl_waddr),
		.wdata(tbl_wdata),
		.raddr(tbl_raddr),
		.rdata(tbl_rdata)
	);

	pli_divider u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(div_dividend),
		.divisor (div_divisor),
		.quotient(div_quotient),
		.status  (div_status)
	);

endmodule

// ===== hw/rtl/pli_table.sv =====
// Breakpoint table: one synchronous memory of (y, x) pairs, x in the low half.
// One write port and one registered read port. Uses pli_pkg.
module pli_table #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [AW-1:0]               waddr,
	input  logic [pli_pkg::ENTRY_W-1:0] wdata,
	input  logic [AW-1:0]               raddr,
	output logic [pli_pkg::ENTRY_W-1:0] rdata
);
	import pli_pkg::*;

	logic [ENTRY_W-1:0] mem [DEPTH];
	logic [ENTRY_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== hw/rtl/pli_divider.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
// PROD_W-bit dividend by DATA_W-bit nonzero divisor. Uses pli_pkg.
module pli_divider (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [pli_pkg::PROD_W-1:0] dividend,
	input  logic [pli_pkg::DATA_W-1:0] divisor,
	output logic [pli_pkg::PROD_W-1:0] quotient,
	output pli_pkg::div_status_t       status
);
	import pli_pkg::*;

	localparam int STEP_W = $clog2(PROD_W + 1);

	logic [DATA_W-1:0] rem_q;
	logic [DATA_W-1:0] dsr_q;
	logic [PROD_W-1:0] quo_q;
	logic [STEP_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DATA_W:0]   shifted;
	logic [DATA_W:0]   diff;
	logic              fits;

	assign shifted = {rem_q, quo_q[PROD_W-1]};
	assign diff    = shifted - {1'b0, dsr_q};
	assign fits    = shifted >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= STEP_W'(PROD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dsr_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
			quo_q <= {quo_q[PROD_W-2:0], fits};
		end
	end

	assign quotient    = quo_q;
	assign status.busy = busy_q;
	assign status.done = done_q;

endmodule

// ===== hw/rtl/pli_ctrl.sv =====
// Lookup sequencer: table writes, breakpoint search over the table memory,
// multiply and division setup, result saturation. Uses pli_pkg, drives pli_table
// and pli_divider through the top level.
module pli_ctrl #(
	parameter int MAX_POINTS = 16,
	parameter int AW         = 4
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [pli_pkg::CNT_W-1:0]   point_count,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        in_mode,
	input  logic [pli_pkg::IDX_W-1:0]   in_index,
	input  logic [pli_pkg::DATA_W-1:0]  in_x,
	input  logic [pli_pkg::DATA_W-1:0]  in_y,
	input  logic [pli_pkg::DATA_W-1:0]  in_sample,
	output logic                        tbl_we,
	output logic [AW-1:0]               tbl_waddr,
	output logic [pli_pkg::ENTRY_W-1:0] tbl_wdata,
	output logic [AW-1:0]               tbl_raddr,
	input  logic [pli_pkg::ENTRY_W-1:0] tbl_rdata,
	output logic                        div_start,
	output logic [pli_pkg::PROD_W-1:0]  div_dividend,
	output logic [pli_pkg::DATA_W-1:0]  div_divisor,
	input  logic [pli_pkg::PROD_W-1:0]  div_quotient,
	input  pli_pkg::div_status_t        div_status,
	input  logic                        out_free,
	output logic                        res_valid,
	output logic [pli_pkg::DATA_W-1:0]  res_value
);
	import pli_pkg::*;

	localparam int NW = ($clog2(MAX_POINTS + 1) > CNT_W) ? $clog2(MAX_POINTS + 1) : CNT_W;
	localparam logic [DATA_W:0] DMAX = {1'b0, {DATA_W{1'b1}}};

	pli_state_t state_q, state_d;

	logic [DATA_W-1:0] sample_q;
	logic [AW-1:0]     p_q;
	logic [DATA_W-1:0] x0_q, y0_q, x1_q, y1_q;
	logic [DATA_W-1:0] res_q;
	logic [PROD_W-1:0] prod_q;
	logic [DATA_W-1:0] dsr_q;
	logic              neg_q;

	logic [NW-1:0]     cnt_ext, used;
	logic [AW-1:0]     last_idx;
	logic [DATA_W-1:0] rd_x, rd_y;
	logic              accept;
	logic              stop_scan;
	logic [DATA_W-1:0] dx, dq, dy;
	logic              neg;
	logic [PROD_W:0]   sum_pos;
	logic [DATA_W-1:0] res_div;

	assign rd_x = tbl_rdata[DATA_W-1:0];
	assign rd_y = tbl_rdata[ENTRY_W-1:DATA_W];

	always_comb begin
		cnt_ext = NW'(point_count);
		if (cnt_ext == '0) begin
			used = NW'(1);
		end else if (cnt_ext > NW'(MAX_POINTS)) begin
			used = NW'(MAX_POINTS);
		end else begin
			used = cnt_ext;
		end
	end
	assign last_idx = AW'(used - NW'(1));

	assign accept    = in_valid && in_ready;
	assign tbl_we    = accept && (in_mode == MODE_LOAD) &&
	                   ({{(32-IDX_W){1'b0}}, in_index} < 32'(MAX_POINTS));
	assign tbl_waddr = AW'(in_index);
	assign tbl_wdata = {in_y, in_x};

	assign stop_scan = (p_q == last_idx) || (sample_q <= rd_x);

	always_comb begin
		neg = 1'b0;
		if (sample_q >= x0_q) begin
			dx = sample_q - x0_q;
		end else begin
			dx  = x0_q - sample_q;
			neg = ~neg;
		end
		if (x1_q >= x0_q) begin
			dq = x1_q - x0_q;
		end else begin
			dq  = x0_q - x1_q;
			neg = ~neg;
		end
		if (y1_q >= y0_q) begin
			dy = y1_q - y0_q;
		end else begin
			dy  = y0_q - y1_q;
			neg = ~neg;
		end
	end

	assign sum_pos = {{(PROD_W-DATA_W+1){1'b0}}, y0_q} + {1'b0, div_quotient};
	always_comb begin
		if (neg_q) begin
			if (div_quotient > PROD_W'(y0_q)) begin
				res_div = '0;
			end else begin
				res_div = y0_q - div_quotient[DATA_W-1:0];
			end
		end else if (sum_pos > (PROD_W+1)'(DMAX)) begin
			res_div = DMAX[DATA_W-1:0];
		end else begin
			res_div = sum_pos[DATA_W-1:0];
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && in_mode == MODE_LOOKUP) state_d = ST_CHK0;
			end
			ST_CHK0: state_d = (sample_q <= rd_x) ? ST_FIN : ST_CHKL;
			ST_CHKL: state_d = (sample_q >= rd_x) ? ST_FIN : ST_SCAN;
			ST_SCAN: begin
				if (stop_scan) state_d = (sample_q == rd_x) ? ST_FIN : ST_MUL;
			end
			ST_MUL:       state_d = (x1_q == x0_q) ? ST_FIN : ST_DIV_START;
			ST_DIV_START: state_d = ST_DIV;
			ST_DIV: begin
				if (div_status.done) state_d = ST_FIN;
			end
			ST_FIN: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		tbl_raddr = '0;
		div_start = 1'b0;
		res_valid = 1'b0;
		unique case (state_q)
			ST_IDLE:      in_ready  = 1'b1;
			ST_CHK0:      tbl_raddr = last_idx;
			ST_CHKL:      tbl_raddr = AW'(1);
			ST_SCAN:      tbl_raddr = p_q + AW'(1);
			ST_MUL:       tbl_raddr = '0;
			ST_DIV_START: div_start = 1'b1;
			ST_DIV:       tbl_raddr = '0;
			ST_FIN:       res_valid = 1'b1;
			default:      tbl_raddr = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				sample_q <= in_sample;
			end
			ST_CHK0: begin
				x0_q  <= rd_x;
				y0_q  <= rd_y;
				res_q <= rd_y;
			end
			ST_CHKL: begin
				res_q <= rd_y;
				p_q   <= AW'(1);
			end
			ST_SCAN: begin
				if (stop_scan) begin
					x1_q  <= rd_x;
					y1_q  <= rd_y;
					res_q <= rd_y;
				end else begin
					x0_q <= rd_x;
					y0_q <= rd_y;
					p_q  <= p_q + AW'(1);
				end
			end
			ST_MUL: begin
				prod_q <= PROD_W'(dx) * PROD_W'(dy);
				dsr_q  <= dq;
				neg_q  <= neg;
				res_q  <= y1_q;
			end
			ST_DIV_START: begin
				res_q <= res_q;
			end
			ST_DIV: begin
				if (div_status.done) res_q <= res_div;
			end
			ST_FIN: begin
				res_q <= res_q;
			end
			default: begin
				res_q <= res_q;
			end
		endcase
	end

	assign div_dividend = prod_q;
	assign div_divisor  = dsr_q;
	assign res_value    = res_q;

endmodule

// ===== tb/piecewise_linear_interpolator_tb.sv =====
// Testbench for piecewise_linear_interpolator: loads breakpoint tables, runs
// lookups under varied point_count settings and handshake idling, and checks
// every mapped_value beat against a scoreboard-held table model. Needs pli_pkg.
module piecewise_linear_interpolator_tb;
	import pli_pkg::*;

	localparam logic [2:0] COUNT_ADDR = 3'd0;
	localparam int TABLE_DEPTH = 16;
	localparam int SETTLE_CYCLES = 64;
	localparam int SEG_ITEMS = 203;

	class interp_scoreboard;
		logic [DATA_W-1:0] bp_x [TABLE_DEPTH];
		logic [DATA_W-1:0] bp_y [TABLE_DEPTH];
		logic [CNT_W-1:0] count_reg = POINT_COUNT_RESET;
		logic [DATA_W-1:0] pending_values [$];
		int mismatches = 0;
		int loads_seen = 0;
		int lookups_checked = 0;

		function void flag(string what, logic [31:0] want, logic [31:0] got);
			mismatches++;
			if (mismatches <= 10)
				$display("MISMATCH %s: expected 0x%0h, got 0x%0h", what, want, got);
		endfunction

		function void set_count(logic [CNT_W-1:0] v);
			count_reg = v;
		endfunction

		function logic [DATA_W-1:0] map_sample(logic [DATA_W-1:0] s);
			int unsigned n;
			int unsigned p;
			logic [DATA_W-1:0] x0, x1, y0, y1, dx, dy, span;
			logic [31:0] q;
			bit neg;
			n = count_reg;
			if (n < 1) n = 1;
			if (n > TABLE_DEPTH) n = TABLE_DEPTH;
			if (s <= bp_x[0]) return bp_y[0];
			if (s >= bp_x[n-1]) return bp_y[n-1];
			p = 1;
			while (p < n - 1 && s > bp_x[p]) p++;
			if (s == bp_x[p]) return bp_y[p];
			x0 = bp_x[p-1];
			x1 = bp_x[p];
			y0 = bp_y[p-1];
			y1 = bp_y[p];
			if (x1 == x0) return y1;
			neg = 1'b0;
			if (s >= x0) begin
				dx = s - x0;
			end else begin
				dx = x0 - s;
				neg = !neg;
			end
			if (x1 >= x0) begin
				span = x1 - x0;
			end else begin
				span = x0 - x1;
				neg = !neg;
			end
			if (y1 >= y0) begin
				dy = y1 - y0;
			end else begin
				dy = y0 - y1;
				neg = !neg;
			end
			q = (32'(dx) * 32'(dy)) / 32'(span);
			if (neg) return (q > 32'(y0)) ? '0 : DATA_W'(32'(y0) - q);
			return (32'(y0) + q > 32'hFFFF) ? '1 : DATA_W'(32'(y0) + q);
		endfunction

		function void note_input(logic mode, logic [IDX_W-1:0] idx, logic [DATA_W-1:0] px,
				logic [DATA_W-1:0] py, logic [DATA_W-1:0] smp);
			if (mode == MODE_LOAD) begin
				bp_x[idx] = px;
				bp_y[idx] = py;
				loads_seen++;
			end else begin
				pending_values.push_back(map_sample(smp));
			end
		endfunction

		function void check_result(logic [DATA_W-1:0] got);
			logic [DATA_W-1:0] want;
			if (pending_values.size() == 0) begin
				flag("mapped_value beat with no lookup pending", 32'd0, 32'(got));
				return;
			end
			want = pending_values.pop_front();
			lookups_checked++;
			if (got !== want) flag("mapped_value", 32'(want), 32'(got));
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [S_TDATA_W-1:0] s_tdata;
	logic s_tuser;
	logic m_tvalid;
	logic m_tready;
	logic [DATA_W-1:0] m_tdata;
	logic psel;
	logic penable;
	logic pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	interp_scoreboard sb;
	int send_idle_pct = 18;
	int recv_idle_pct = 50;
	int items_sent = 0;
	int settings_used = 0;

	piecewise_linear_interpolator uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		#20_000_000;
		$display("piecewise_linear_interpolator verification failed");
		$finish;
	end

	// result side: check on handshake, then pick next tready
	initial begin
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) sb.check_result(m_tdata);
			m_tready <= !(recv_idle_pct != 0 && $urandom_range(99) < recv_idle_pct);
		end
	end

	task automatic send_beat(input logic mode, input logic [IDX_W-1:0] idx,
			input logic [DATA_W-1:0] px, input logic [DATA_W-1:0] py,
			input logic [DATA_W-1:0] smp);
		logic [S_TDATA_W-1:0] beat;
		beat = '0;
		beat[S_IDX_LO +: IDX_W] = idx;
		beat[S_X_LO +: DATA_W] = px;
		beat[S_Y_LO +: DATA_W] = py;
		beat[S_SMP_LO +: DATA_W] = smp;
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= mode;
		s_tdata <= beat;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_input(mode, idx, px, py, smp);
		items_sent++;
	endtask

	task automatic lookup(input logic [DATA_W-1:0] smp);
		send_beat(MODE_LOOKUP, 4'($urandom), 16'($urandom), 16'($urandom), smp);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending_values.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_point_count(input logic [CNT_W-1:0] v);
		logic [31:0] rd;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= COUNT_ADDR;
		pwdata <= 32'(v);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		sb.set_count(v);
		settings_used++;
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		rd = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		if (rd !== 32'(v)) sb.flag("point_count readback", 32'(v), rd);
	endtask

	task automatic load_sorted_table();
		int unsigned base;
		int unsigned step_max;
		int unsigned xv;
		int i;
		case ($urandom_range(2))
			0: begin
				base = $urandom_range(300);
				step_max = 4400;
			end
			1: begin
				base = $urandom_range(65535);
				step_max = 20;
			end
			default: begin
				base = $urandom_range(30000);
				step_max = 2000;
			end
		endcase
		xv = base;
		for (i = 0; i < TABLE_DEPTH; i++) begin
			if (xv > 65535) xv = 65535;
			send_beat(MODE_LOAD, 4'(i), 16'(xv), 16'($urandom), 16'($urandom));
			xv = xv + $urandom_range(step_max);
		end
	endtask

	function automatic logic [DATA_W-1:0] pick_sample();
		int unsigned k;
		k = $urandom_range(TABLE_DEPTH - 2);
		case ($urandom_range(9))
			0: return 16'($urandom);
			1: return '0;
			2: return '1;
			3: return sb.bp_x[k];
			4: return sb.bp_x[k] + 1'b1;
			5: return sb.bp_x[k] - 1'b1;
			default: return 16'($urandom_range(sb.bp_x[k], sb.bp_x[k+1]));
		endcase
	endfunction

	initial begin
		logic [DATA_W-1:0] dir_x [TABLE_DEPTH];
		logic [DATA_W-1:0] dir_y [TABLE_DEPTH];
		logic [CNT_W-1:0] seg_counts [9];
		logic [31:0] rd;
		int seg;
		int quota;
		int r;
		int i;
		dir_x = '{10, 20, 30, 1000, 1001, 5000, 20000, 40000, 60000, 61000, 62000,
			63000, 64000, 65000, 65534, 65535};
		dir_y = '{65535, 0, 100, 65535, 0, 300, 301, 12345, 7, 1, 2, 3, 4, 5, 6, 65535};
		seg_counts = '{16, 0, 5, 31, 1, 12, 17, 2, 9};
		sb = new;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = MODE_LOAD;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = COUNT_ADDR;
		pwdata = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset value of point_count
		psel <= 1'b1;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		rd = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		if (rd !== 32'(POINT_COUNT_RESET))
			sb.flag("point_count reset", 32'(POINT_COUNT_RESET), rd);
		@(posedge clk);

		// directed: fill the whole table, then clamp, exact and both slopes
		for (i = 0; i < TABLE_DEPTH; i++)
			send_beat(MODE_LOAD, 4'(i), dir_x[i], dir_y[i], 16'($urandom));
		lookup(16'd0);
		lookup(16'd15);
		lookup(16'd1000);
		lookup(16'd3000);
		lookup(16'd65535);
		drain();
		set_point_count(5'd0);
		lookup(16'd500);
		drain();
		set_point_count(5'd31);
		lookup(16'd65535);
		lookup(16'd64500);
		// unsorted entry inside the used range
		send_beat(MODE_LOAD, 4'd5, 16'd50, 16'd40000, 16'hFFFF);
		lookup(16'd2000);

		for (seg = 0; seg < 9; seg++) begin
			drain();
			send_idle_pct = (seg < 3) ? 18 : (seg < 6) ? 50 : 0;
			recv_idle_pct = (seg < 3) ? 50 : (seg < 6) ? 18 : 0;
			set_point_count(seg_counts[seg]);
			@(posedge clk);
			quota = items_sent + SEG_ITEMS;
			load_sorted_table();
			while (items_sent < quota) begin
				r = $urandom_range(99);
				if (r < 2)
					load_sorted_table();
				else if (r < 7)
					send_beat(MODE_LOAD, 4'($urandom), 16'($urandom), 16'($urandom),
						16'($urandom));
				else
					lookup(pick_sample());
			end
		end
		drain();

		$display("Covered %0d load beats and %0d checked lookups over %0d point_count writes,",
			sb.loads_seen, sb.lookups_checked, settings_used);
		$display("including counts 0, 1, 16, 17 and 31, under three idling patterns.");
		if (sb.mismatches == 0) begin
			$display("piecewise_linear_interpolator verification clean");
		end else begin
			$display("%0d mismatches in total", sb.mismatches);
			$display("piecewise_linear_interpolator verification failed");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/pli_pkg.sv
hw/rtl/pli_table.sv
hw/rtl/pli_divider.sv
hw/rtl/pli_ctrl.sv
hw/rtl/piecewise_linear_interpolator.sv
tb/piecewise_linear_interpolator_tb.sv
